FILE: rtl/csrr_pkg.sv
// ----------------------------------------------------------------------------
// csrr_pkg
// Shared types, constants and the character classes of the space run remover.
// ----------------------------------------------------------------------------
package csrr_pkg;

	localparam int CP_W    = 21;
	localparam int TDATA_W = 24;
	localparam int TUSER_W = 2;

	localparam logic [CP_W-1:0] CP_SPACE = 21'h00020;
	localparam logic [CP_W-1:0] CP_TAB   = 21'h00009;

	// CJK ranges, inclusive bounds.
	localparam logic [CP_W-1:0] CJK_PUNCT_LO = 21'h03000;
	localparam logic [CP_W-1:0] CJK_PUNCT_HI = 21'h0303F;
	localparam logic [CP_W-1:0] KANA_LO      = 21'h03040;
	localparam logic [CP_W-1:0] KANA_HI      = 21'h030FF;
	localparam logic [CP_W-1:0] HAN_EXT_A_LO = 21'h03400;
	localparam logic [CP_W-1:0] HAN_EXT_A_HI = 21'h04DBF;
	localparam logic [CP_W-1:0] HAN_LO       = 21'h04E00;
	localparam logic [CP_W-1:0] HAN_HI       = 21'h09FFF;
	localparam logic [CP_W-1:0] HANGUL_LO    = 21'h0AC00;
	localparam logic [CP_W-1:0] HANGUL_HI    = 21'h0D7A3;
	localparam logic [CP_W-1:0] HAN_COMPAT_LO = 21'h0F900;
	localparam logic [CP_W-1:0] HAN_COMPAT_HI = 21'h0FAFF;
	localparam logic [CP_W-1:0] FULLWIDTH_LO = 21'h0FF00;
	localparam logic [CP_W-1:0] FULLWIDTH_HI = 21'h0FF60;
	localparam logic [CP_W-1:0] FW_SIGNS_LO  = 21'h0FFE0;
	localparam logic [CP_W-1:0] FW_SIGNS_HI  = 21'h0FFE6;
	localparam logic [CP_W-1:0] HAN_PLANE_LO = 21'h20000;
	localparam logic [CP_W-1:0] HAN_PLANE_HI = 21'h3FFFF;

	// Source of the character loaded into the output register.
	typedef enum logic [1:0] {
		SRC_IN,
		SRC_PEND,
		SRC_HELD
	} src_t;

	typedef struct packed {
		logic accept;
		logic push;
		logic pop;
		logic clr_count;
		logic text_reset;
		logic prev_load;
		logic pass_set;
		logic pass_clr;
		logic out_load;
		src_t src;
		logic ovf;
		logic burst_end;
		logic text_end;
	} cmd_t;

	typedef struct packed {
		logic in_blank;
		logic in_cjk;
		logic pass;
		logic prev_cjk;
		logic count_zero;
		logic count_full;
		logic count_last;
		logic out_free;
	} sts_t;

	function automatic logic is_cjk(input logic [CP_W-1:0] c);
		return (c >= CJK_PUNCT_LO  && c <= CJK_PUNCT_HI)  ||
		       (c >= KANA_LO       && c <= KANA_HI)       ||
		       (c >= HAN_EXT_A_LO  && c <= HAN_EXT_A_HI)  ||
		       (c >= HAN_LO        && c <= HAN_HI)        ||
		       (c >= HANGUL_LO     && c <= HANGUL_HI)     ||
		       (c >= HAN_COMPAT_LO && c <= HAN_COMPAT_HI) ||
		       (c >= FULLWIDTH_LO  && c <= FULLWIDTH_HI)  ||
		       (c >= FW_SIGNS_LO   && c <= FW_SIGNS_HI)   ||
		       (c >= HAN_PLANE_LO  && c <= HAN_PLANE_HI);
	endfunction

	function automatic logic is_blank(input logic [CP_W-1:0] c);
		return (c == CP_SPACE) || (c == CP_TAB);
	endfunction

endpackage

FILE: rtl/cjk_space_run_remover.sv
// ----------------------------------------------------------------------------
// cjk_space_run_remover
// Holds back runs of spaces and tabs and drops a run of at most MAX_RUN blanks
// between two CJK characters; otherwise the run is replayed before the next character.
// ----------------------------------------------------------------------------
// Output: a request with no replay loads its result into the output register at the
// edge that accepts it; a replay moves to the replay state first and loads from there.
// Throughput: one request per cycle while no run is replayed and the output is free;
// a request that replays N held blanks sends N + 1 results (N for a blank ending
// the text), one per cycle while the output is free, then input is ready again.
// Reset: arst_n clears the controller, the run count, the class flags and the
// output valid; the run store itself is not cleared and needs no clearing pass.
module cjk_space_run_remover #(
	parameter int MAX_RUN = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [csrr_pkg::TDATA_W-1:0]    s_tdata,  // [20:0] code_point, rest zero
	input  logic                            s_tlast,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [csrr_pkg::TDATA_W-1:0]    m_tdata,  // [20:0] char_out, rest zero
	output logic [csrr_pkg::TUSER_W-1:0]    m_tuser,  // [0] burst_end, [1] run_overflowed
	output logic                            m_tlast
);

	csrr_pkg::cmd_t                 cmd;
	csrr_pkg::sts_t                 sts;
	logic [csrr_pkg::CP_W-1:0]      out_char;
	logic                           out_be;
	logic                           out_ovf;

	csrr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_eot   (s_tlast),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	csrr_dpath #(
		.MAX_RUN (MAX_RUN)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_cp         (s_tdata[csrr_pkg::CP_W-1:0]),
		.cmd           (cmd),
		.sts           (sts),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.out_char      (out_char),
		.out_burst_end (out_be),
		.out_text_end  (m_tlast),
		.out_ovf       (out_ovf)
	);

	assign m_tdata = {{(csrr_pkg::TDATA_W - csrr_pkg::CP_W){1'b0}}, out_char};
	assign m_tuser = {out_ovf, out_be};

endmodule

FILE: rtl/csrr_dpath.sv
// ----------------------------------------------------------------------------
// csrr_dpath
// Datapath: classifies the incoming character, holds the pending blank run
// as a shift line of kind bits, and owns the output register.
// ----------------------------------------------------------------------------
module csrr_dpath #(
	parameter int MAX_RUN = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [csrr_pkg::CP_W-1:0]    in_cp,
	input  csrr_pkg::cmd_t               cmd,
	output csrr_pkg::sts_t               sts,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [csrr_pkg::CP_W-1:0]    out_char,
	output logic                         out_burst_end,
	output logic                         out_text_end,
	output logic                         out_ovf
);

	localparam int CW = $clog2(MAX_RUN + 1);
	localparam int IW = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;

	logic [CW-1:0]                count_q;
	logic [MAX_RUN-1:0]           kinds_q;
	logic                         prev_cjk_q;
	logic                         pass_q;
	logic [csrr_pkg::CP_W-1:0]    hold_cp_q;
	logic                         out_valid_q;
	logic [csrr_pkg::CP_W-1:0]    out_char_q;
	logic                         out_be_q;
	logic                         out_te_q;
	logic                         out_ovf_q;

	logic                         in_cjk;
	logic [csrr_pkg::CP_W-1:0]    char_sel;

	assign in_cjk = csrr_pkg::is_cjk(in_cp);

	assign sts.in_blank   = csrr_pkg::is_blank(in_cp);
	assign sts.in_cjk     = in_cjk;
	assign sts.pass       = pass_q;
	assign sts.prev_cjk   = prev_cjk_q;
	assign sts.count_zero = (count_q == '0);
	assign sts.count_full = (count_q == CW'(MAX_RUN));
	assign sts.count_last = (count_q == CW'(1));
	assign sts.out_free   = !out_valid_q || out_ready;

	always_comb begin
		unique case (cmd.src)
			csrr_pkg::SRC_IN:   char_sel = in_cp;
			csrr_pkg::SRC_PEND: char_sel = kinds_q[0] ? csrr_pkg::CP_TAB : csrr_pkg::CP_SPACE;
			csrr_pkg::SRC_HELD: char_sel = hold_cp_q;
			default:            char_sel = in_cp;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			prev_cjk_q  <= 1'b0;
			pass_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.text_reset || cmd.clr_count) begin
				count_q <= '0;
			end else if (cmd.push) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.pop) begin
				count_q <= count_q - CW'(1);
			end

			if (cmd.text_reset) begin
				prev_cjk_q <= 1'b0;
			end else if (cmd.prev_load) begin
				prev_cjk_q <= in_cjk;
			end

			if (cmd.text_reset || cmd.pass_clr) begin
				pass_q <= 1'b0;
			end else if (cmd.pass_set) begin
				pass_q <= 1'b1;
			end

			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers carry no reset. Entries at or above the count are stale.
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			kinds_q[count_q[IW-1:0]] <= (in_cp == csrr_pkg::CP_TAB);
		end else if (cmd.pop) begin
			kinds_q <= kinds_q >> 1;
		end
		if (cmd.accept) begin
			hold_cp_q <= in_cp;
		end
		if (cmd.out_load) begin
			out_char_q <= char_sel;
			out_be_q   <= cmd.burst_end;
			out_te_q   <= cmd.text_end;
			out_ovf_q  <= cmd.ovf;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_char      = out_char_q;
	assign out_burst_end = out_be_q;
	assign out_text_end  = out_te_q;
	assign out_ovf       = out_ovf_q;

endmodule

FILE: rtl/csrr_ctrl.sv
// ----------------------------------------------------------------------------
// csrr_ctrl
// Controller: decides per request whether the held run is kept, dropped or
// replayed, and sequences the replay and the trailing character.
// ----------------------------------------------------------------------------
module csrr_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_eot,
	output logic            in_ready,
	input  csrr_pkg::sts_t  sts,
	output csrr_pkg::cmd_t  cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_REPLAY,
		ST_CHAR
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   ovf_q, ovf_d;
	logic   tail_q, tail_d;
	logic   eot_q, eot_d;
	logic   accept;

	assign in_ready = (state_q == ST_IDLE) && sts.out_free;
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd     = '0;
		cmd.src = csrr_pkg::SRC_IN;
		state_d = state_q;
		ovf_d   = ovf_q;
		tail_d  = tail_q;
		eot_d   = eot_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.accept = 1'b1;
					if (sts.in_blank) begin
						if (sts.pass) begin
							cmd.out_load   = 1'b1;
							cmd.ovf        = 1'b1;
							cmd.burst_end  = 1'b1;
							cmd.text_end   = in_eot;
							cmd.text_reset = in_eot;
						end else if (sts.count_full) begin
							// Overflow: the held run goes out flagged, then this blank.
							cmd.pass_set = 1'b1;
							state_d      = ST_REPLAY;
							ovf_d        = 1'b1;
							tail_d       = 1'b1;
							eot_d        = in_eot;
						end else begin
							cmd.push = 1'b1;
							if (in_eot) begin
								state_d = ST_REPLAY;
								ovf_d   = 1'b0;
								tail_d  = 1'b0;
								eot_d   = 1'b1;
							end
						end
					end else begin
						cmd.prev_load = 1'b1;
						cmd.pass_clr  = 1'b1;
						if (!sts.count_zero && !(sts.prev_cjk && sts.in_cjk)) begin
							state_d = ST_REPLAY;
							ovf_d   = 1'b0;
							tail_d  = 1'b1;
							eot_d   = in_eot;
						end else begin
							// A run between two CJK characters is dropped here.
							cmd.clr_count  = 1'b1;
							cmd.out_load   = 1'b1;
							cmd.burst_end  = 1'b1;
							cmd.text_end   = in_eot;
							cmd.text_reset = in_eot;
						end
					end
				end
			end
			ST_REPLAY: begin
				if (sts.out_free) begin
					cmd.out_load  = 1'b1;
					cmd.src       = csrr_pkg::SRC_PEND;
					cmd.pop       = 1'b1;
					cmd.ovf       = ovf_q;
					cmd.burst_end = sts.count_last && !tail_q;
					cmd.text_end  = sts.count_last && !tail_q && eot_q;
					if (sts.count_last) begin
						if (tail_q) begin
							state_d = ST_CHAR;
						end else begin
							cmd.text_reset = eot_q;
							state_d        = ST_IDLE;
						end
					end
				end
			end
			ST_CHAR: begin
				if (sts.out_free) begin
					cmd.out_load   = 1'b1;
					cmd.src        = csrr_pkg::SRC_HELD;
					cmd.ovf        = ovf_q;
					cmd.burst_end  = 1'b1;
					cmd.text_end   = eot_q;
					cmd.text_reset = eot_q;
					state_d        = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ovf_q   <= 1'b0;
			tail_q  <= 1'b0;
			eot_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			ovf_q   <= ovf_d;
			tail_q  <= tail_d;
			eot_q   <= eot_d;
		end
	end

endmodule

FILE: rtl/csrr_checker.sv
// ----------------------------------------------------------------------------
// csrr_checker
// Port-level checks of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module csrr_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [csrr_pkg::TDATA_W-1:0]    m_tdata,
	input  logic [csrr_pkg::TUSER_W-1:0]    m_tuser,
	input  logic                            m_tlast
);

	logic out_blank;

	assign out_blank = (m_tdata[csrr_pkg::TDATA_W-1:csrr_pkg::CP_W] == '0) &&
		csrr_pkg::is_blank(m_tdata[csrr_pkg::CP_W-1:0]);

	// A stalled result must not change.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("result changed while stalled");

	// The end of a text is always the last result of its request.
	a_end_in_burst: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser[0])
		else $error("text end without burst end");

	// Only blanks can be flagged as overflowed.
	a_ovf_blank: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> out_blank)
		else $error("overflow flag on a non-blank");

	// A non-blank always closes the results of its request.
	a_char_closes: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !out_blank |-> m_tuser[0])
		else $error("non-blank result without burst end");

endmodule

bind cjk_space_run_remover csrr_checker u_csrr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

FILE: verif/cjk_space_run_remover_test.sv
// ----------------------------------------------------------------------------
// cjk_space_run_remover_test
// Streams short texts of CJK, Latin, out-of-range and blank code points into
// the space run remover. A local predictor of the run filter builds the
// expected output characters, and every output request is compared with them.
// ----------------------------------------------------------------------------
module cjk_space_run_remover_test;

	localparam int CP_W    = csrr_pkg::CP_W;
	localparam int TDATA_W = csrr_pkg::TDATA_W;
	localparam int TUSER_W = csrr_pkg::TUSER_W;
	localparam logic [CP_W-1:0] CP_SPACE = csrr_pkg::CP_SPACE;
	localparam logic [CP_W-1:0] CP_TAB   = csrr_pkg::CP_TAB;

	localparam int HELD_MAX   = 32;
	localparam int TAIL_ITEMS = 60;
	localparam int CYCLE_CAP  = 600000;
	localparam int RAND_ITEMS = 290;

	typedef struct packed {
		logic [CP_W-1:0] cp;
		logic            eot;
	} text_item_t;

	typedef struct packed {
		logic [CP_W-1:0] ch;
		logic            burst_end;
		logic            text_end;
		logic            ovf;
	} out_char_t;

	typedef enum int {
		CH_CJK,
		CH_LATIN,
		CH_ANY,
		CH_EDGE,
		CH_ODD
	} char_kind_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [TDATA_W-1:0]  s_tdata = '0;
	logic                s_tlast = 1'b0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [TDATA_W-1:0]  m_tdata;
	logic [TUSER_W-1:0]  m_tuser;
	logic                m_tlast;

	// Inclusive bounds of the CJK blocks.
	logic [CP_W-1:0] cjk_lo [9] = '{21'h03000, 21'h03040, 21'h03400, 21'h04E00,
		21'h0AC00, 21'h0F900, 21'h0FF00, 21'h0FFE0, 21'h20000};
	logic [CP_W-1:0] cjk_hi [9] = '{21'h0303F, 21'h030FF, 21'h04DBF, 21'h09FFF,
		21'h0D7A3, 21'h0FAFF, 21'h0FF60, 21'h0FFE6, 21'h3FFFF};

	text_item_t text_items [$];
	out_char_t  chars_due [$];

	// Filter state.
	logic prev_cjk = 1'b0;
	logic held_tab [HELD_MAX];
	int   held_count = 0;
	logic passing = 1'b0;

	int mismatches = 0;
	int cycles = 0;
	int in_gap = 0;
	int in_calm = 0;
	int out_stall = 0;
	int out_calm = 0;
	text_item_t next_item;
	out_char_t  got_char;

	cjk_space_run_remover #(
		.MAX_RUN(HELD_MAX)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	function automatic logic in_cjk_block(input logic [CP_W-1:0] c);
		logic hit;
		hit = 1'b0;
		for (int i = 0; i < 9; i++)
			if (c >= cjk_lo[i] && c <= cjk_hi[i])
				hit = 1'b1;
		return hit;
	endfunction

	function automatic void push_char(input logic [CP_W-1:0] c, input logic ovf);
		out_char_t r;
		r.ch = c;
		r.burst_end = 1'b0;
		r.text_end = 1'b0;
		r.ovf = ovf;
		chars_due.push_back(r);
	endfunction

	function automatic int replay_held(input logic ovf);
		int n;
		n = held_count;
		for (int i = 0; i < held_count; i++)
			push_char(held_tab[i] ? CP_TAB : CP_SPACE, ovf);
		held_count = 0;
		return n;
	endfunction

	// Works out the output characters caused by one accepted request.
	function automatic void filter_char(input logic [CP_W-1:0] cp, input logic eot);
		int n;
		logic cur_cjk;
		out_char_t r;
		n = 0;
		if (cp == CP_SPACE || cp == CP_TAB) begin
			if (passing) begin
				push_char(cp, 1'b1);
				n++;
			end else if (held_count >= HELD_MAX) begin
				n = replay_held(1'b1);
				push_char(cp, 1'b1);
				n++;
				passing = 1'b1;
			end else begin
				held_tab[held_count] = (cp == CP_TAB);
				held_count++;
				if (eot)
					n = replay_held(1'b0);
			end
		end else begin
			cur_cjk = in_cjk_block(cp);
			if (held_count > 0) begin
				if (prev_cjk && cur_cjk)
					held_count = 0;
				else
					n = replay_held(1'b0);
			end
			passing = 1'b0;
			push_char(cp, 1'b0);
			n++;
			prev_cjk = cur_cjk;
		end
		if (n > 0) begin
			r = chars_due[chars_due.size()-1];
			r.burst_end = 1'b1;
			r.text_end = eot;
			chars_due[chars_due.size()-1] = r;
		end
		if (eot) begin
			prev_cjk = 1'b0;
			held_count = 0;
			passing = 1'b0;
		end
	endfunction

	function automatic logic [CP_W-1:0] pick_char(input char_kind_t k);
		int i;
		logic [CP_W-1:0] c;
		i = $urandom_range(0, 8);
		case (k)
			CH_CJK:   c = CP_W'($urandom_range(cjk_lo[i], cjk_hi[i]));
			CH_LATIN: c = CP_W'($urandom_range(8'h21, 8'h7E));
			CH_ANY:   c = CP_W'($urandom);
			CH_EDGE: begin
				case ($urandom_range(0, 3))
					0: c = cjk_lo[i] - CP_W'(1);
					1: c = cjk_lo[i];
					2: c = cjk_hi[i];
					default: c = cjk_hi[i] + CP_W'(1);
				endcase
			end
			default: c = CP_W'($urandom_range(0, 1) ? $urandom_range(21'h0D800, 21'h0DFFF) :
				$urandom_range(21'h110000, 21'h1FFFFF));
		endcase
		return c;
	endfunction

	task automatic add_item(input logic [CP_W-1:0] cp, input logic eot);
		text_item_t it;
		it.cp = cp;
		it.eot = eot;
		text_items.push_back(it);
	endtask

	task automatic add_run(input int len);
		for (int i = 0; i < len; i++)
			add_item($urandom_range(0, 1) ? CP_TAB : CP_SPACE, 1'b0);
	endtask

	task automatic end_text();
		text_item_t it;
		it = text_items[text_items.size()-1];
		it.eot = 1'b1;
		text_items[text_items.size()-1] = it;
	endtask

	function automatic int pick_run_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return $urandom_range(1, 2);
		else if (r < 82)
			return $urandom_range(3, 8);
		else if (r < 94)
			return $urandom_range(9, 20);
		return $urandom_range(30, 36);
	endfunction

	// One text: words of mostly one kind separated by blank runs.
	task automatic build_text();
		int words;
		int wl;
		int r;
		char_kind_t wk;
		words = $urandom_range(1, 7);
		if ($urandom_range(0, 7) == 0)
			add_run(pick_run_len());
		for (int w = 0; w < words; w++) begin
			r = $urandom_range(0, 99);
			wk = (r < 55) ? CH_CJK : (r < 80) ? CH_LATIN : (r < 90) ? CH_EDGE :
				(r < 95) ? CH_ANY : CH_ODD;
			wl = $urandom_range(1, 4);
			for (int j = 0; j < wl; j++)
				add_item(pick_char(($urandom_range(0, 3) == 0) ?
					char_kind_t'($urandom_range(0, 4)) : wk), 1'b0);
			if (w < words - 1 || $urandom_range(0, 3) == 0)
				add_run(pick_run_len());
		end
		end_text();
	endtask

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		int rand_start;

		// Directed part: block edges, drop and replay cases, odd values.
		add_item(21'h000000, 1'b0);
		add_item(CP_SPACE, 1'b0);
		add_item(CP_TAB, 1'b0);
		add_item(21'h000041, 1'b0);
		add_item(21'h004E00, 1'b0);
		add_item(CP_SPACE, 1'b0);
		add_item(21'h003042, 1'b0);
		add_item(21'h003000, 1'b0);
		add_item(CP_TAB, 1'b0);
		add_item(CP_SPACE, 1'b0);
		add_item(21'h000062, 1'b0);
		add_item(CP_SPACE, 1'b0);
		add_item(21'h00AC00, 1'b0);
		add_item(21'h00D7A3, 1'b0);
		add_item(CP_SPACE, 1'b0);
		add_item(21'h020000, 1'b0);
		add_item(21'h00FFE6, 1'b0);
		add_item(CP_TAB, 1'b0);
		add_item(21'h00FF00, 1'b0);
		add_item(21'h00D800, 1'b0);
		add_item(21'h10FFFF, 1'b0);
		add_item(21'h1FFFFF, 1'b1);
		// A text that starts with a blank counts as non-CJK before the run.
		add_item(CP_SPACE, 1'b0);
		add_item(21'h004E00, 1'b0);
		add_item(CP_TAB, 1'b1);

		// Run overflow between two CJK characters, then an overflow on the
		// blank that ends the text, then a run that just fits.
		add_item(21'h004E00, 1'b0);
		add_run(HELD_MAX + 2);
		add_item(21'h009FFF, 1'b1);
		add_run(HELD_MAX + 1);
		end_text();
		add_item(21'h000071, 1'b0);
		add_run(HELD_MAX);
		end_text();

		rand_start = text_items.size();
		while (text_items.size() - rand_start < RAND_ITEMS)
			build_text();

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (text_items.size() != 0 || s_tvalid)
			@(negedge clk);
		while (chars_due.size() != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Request driver.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tlast <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				filter_char(s_tdata[CP_W-1:0], s_tlast);
			if (!s_tvalid || s_tready) begin
				if (in_gap > 0) begin
					in_gap--;
					s_tvalid <= 1'b0;
				end else if (text_items.size() == 0) begin
					s_tvalid <= 1'b0;
				end else if (text_items.size() > TAIL_ITEMS && in_calm == 0 &&
					$urandom_range(0, 4) == 0) begin
					in_gap = $urandom_range(0, 12);
					in_calm = $urandom_range(0, 40);
					s_tvalid <= 1'b0;
				end else begin
					if (in_calm > 0)
						in_calm--;
					next_item = text_items.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {{(TDATA_W-CP_W){1'b0}}, next_item.cp};
					s_tlast <= next_item.eot;
				end
			end
		end
	end

	// Output monitor with random back-pressure.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (chars_due.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected output: char=%h user=%b last=%b",
							m_tdata, m_tuser, m_tlast);
					mismatches++;
				end else begin
					got_char = chars_due.pop_front();
					if (m_tdata != {{(TDATA_W-CP_W){1'b0}}, got_char.ch} ||
						m_tuser[0] != got_char.burst_end || m_tuser[1] != got_char.ovf ||
						m_tlast != got_char.text_end) begin
						if (mismatches < 10) begin
							$display("mismatch: expected char=%h burst_end=%b ovf=%b text_end=%b",
								got_char.ch, got_char.burst_end, got_char.ovf,
								got_char.text_end);
							$display("          got char=%h burst_end=%b ovf=%b text_end=%b",
								m_tdata, m_tuser[0], m_tuser[1], m_tlast);
						end
						mismatches++;
					end
				end
			end
			if (out_stall > 0) begin
				out_stall--;
				m_tready <= 1'b0;
			end else if (text_items.size() > TAIL_ITEMS && out_calm == 0 &&
				$urandom_range(0, 5) == 0) begin
				out_stall = $urandom_range(0, 12);
				out_calm = $urandom_range(0, 60);
				m_tready <= 1'b0;
			end else begin
				if (out_calm > 0)
					out_calm--;
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_CAP) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

endmodule

FILE: files.f
rtl/csrr_pkg.sv
rtl/csrr_dpath.sv
rtl/csrr_ctrl.sv
rtl/cjk_space_run_remover.sv
rtl/csrr_checker.sv
verif/cjk_space_run_remover_test.sv
